### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked outside reset
`define OAL_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("oal assertion failed");

// property checked at every edge, reset included
`define OAL_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("oal assertion failed");

`else

`define OAL_ASSERT(label, prop)
`define OAL_ASSERT_ALWAYS(label, prop)

`endif

`endif

### hdl/oal_pkg.sv
// types and constants of the ordered array list
package oal_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 8;

	// request operation codes
	typedef enum logic [1:0] {
		MODE_FIND   = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BADPOS   = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// what a cell loads on the next edge
	typedef enum logic [1:0] {
		CMD_HOLD  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_LEFT  = 2'd2,
		CMD_RIGHT = 2'd3
	} cell_cmd_t;

	// control handed to each cell
	typedef struct packed {
		cell_cmd_t          cmd;
		logic               take;
		logic               live;
		logic [VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage

### hdl/oal_ifs.sv
// request and response channel interfaces of the ordered array list
interface oal_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       mode;
	logic signed [oal_pkg::VALUE_W-1:0] value;
	logic [oal_pkg::POS_W-1:0]        position;

	modport source (output valid, mode, value, position, input ready);
	modport sink (input valid, mode, value, position, output ready);
endinterface

interface oal_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [oal_pkg::POS_W-1:0] found_index;
	logic [oal_pkg::POS_W-1:0] count;

	modport source (output valid, status, found_index, count, input ready);
	modport sink (input valid, status, found_index, count, output ready);
endinterface

### hdl/oal_cell.sv
// one list cell: holds an entry, shifts with its neighbors, compares on find
module oal_cell (
	input  logic                          clk,
	input  oal_pkg::cell_ctl_t            ctl,
	input  logic [oal_pkg::VALUE_W-1:0]   left_data,
	input  logic [oal_pkg::VALUE_W-1:0]   right_data,
	output logic [oal_pkg::VALUE_W-1:0]   data,
	output logic                          match
);

	logic [oal_pkg::VALUE_W-1:0] data_q;
	logic                        match_s1;

	// entry register: hold, load new value or take a neighbor's entry
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			oal_pkg::CMD_LOAD:  data_q <= ctl.value;
			oal_pkg::CMD_LEFT:  data_q <= left_data;
			oal_pkg::CMD_RIGHT: data_q <= right_data;
			default:            data_q <= data_q;
		endcase
	end

	// compare against the contents seen by the transaction
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			match_s1 <= ctl.live && (data_q == ctl.value);
		end
	end

	assign data  = data_q;
	assign match = match_s1;

endmodule

### hdl/ordered_array_list_top.sv
// Ordered array list: a row of CAPACITY entry cells with find, insert and delete.
// One request is taken per cycle unless stage 1 is stalled; its response passes
// through the stage 1 registers, then the output register. In the acceptance
// cycle, insert and delete shift the cells from the given position on against
// their neighbors, and find latches one match bit per cell; the output register
// takes the lowest match. Reset empties the list; entry contents are not cleared.
module ordered_array_list_top #(
	parameter int unsigned CAPACITY = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	oal_req_if.sink      req,
	oal_rsp_if.source    rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]                    entry_cnt_q;
	logic                             accept;
	logic                             adv_s1;
	logic                             is_find;
	logic                             is_ins;
	logic                             is_del;
	logic                             full;
	logic                             pos_zero;
	logic                             ins_ok;
	logic                             del_ok;
	logic [oal_pkg::POS_W:0]          pos9;
	logic [oal_pkg::POS_W:0]          cnt9;
	logic [oal_pkg::POS_W-1:0]        p0;
	oal_pkg::status_t                 op_status;

	logic                             valid_s1;
	logic                             find_s1;
	oal_pkg::status_t                 status_s1;
	logic [CW-1:0]                    count_s1;

	logic                             out_valid_q;
	oal_pkg::status_t                 out_status_q;
	logic [oal_pkg::POS_W-1:0]        out_index_q;
	logic [CW-1:0]                    out_count_q;

	oal_pkg::cell_ctl_t               ctl_w   [CAPACITY];
	logic [oal_pkg::VALUE_W-1:0]      data_w  [CAPACITY];
	logic [CAPACITY-1:0]              match_w;
	logic [CAPACITY-1:0]              first_hit;
	logic                             any_hit;
	logic [oal_pkg::POS_W-1:0]        hit_index;

	// handshake
	assign adv_s1    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	// request decode and range checks
	assign is_find  = (req.mode == oal_pkg::MODE_FIND);
	assign is_ins   = (req.mode == oal_pkg::MODE_INSERT);
	assign is_del   = (req.mode == oal_pkg::MODE_DELETE);
	assign full     = (entry_cnt_q == CW'(CAPACITY));
	assign pos9     = {1'b0, req.position};
	assign cnt9     = (oal_pkg::POS_W + 1)'(entry_cnt_q);
	assign pos_zero = (req.position == '0);
	assign ins_ok   = is_ins && !full && !pos_zero && (pos9 <= cnt9 + 9'd1);
	assign del_ok   = is_del && !pos_zero && (pos9 <= cnt9);
	assign p0       = req.position - 8'd1;

	always_comb begin
		if (is_find) begin
			op_status = oal_pkg::ST_OK;
		end else if (is_ins) begin
			op_status = full ? oal_pkg::ST_FULL :
				(ins_ok ? oal_pkg::ST_OK : oal_pkg::ST_BADPOS);
		end else if (is_del) begin
			op_status = del_ok ? oal_pkg::ST_OK : oal_pkg::ST_BADPOS;
		end else begin
			op_status = oal_pkg::ST_BADPOS;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_cnt_q <= '0;
		end else if (accept && ins_ok) begin
			entry_cnt_q <= entry_cnt_q + CW'(1);
		end else if (accept && del_ok) begin
			entry_cnt_q <= entry_cnt_q - CW'(1);
		end
	end

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_comb begin
			ctl_w[i].cmd   = oal_pkg::CMD_HOLD;
			ctl_w[i].take  = accept;
			ctl_w[i].live  = (entry_cnt_q > CW'(i));
			ctl_w[i].value = req.value;
			if (accept && ins_ok) begin
				if (p0 == oal_pkg::POS_W'(i)) begin
					ctl_w[i].cmd = oal_pkg::CMD_LOAD;
				end else if (p0 < oal_pkg::POS_W'(i)) begin
					ctl_w[i].cmd = oal_pkg::CMD_LEFT;
				end
			end else if (accept && del_ok && (p0 <= oal_pkg::POS_W'(i))) begin
				ctl_w[i].cmd = oal_pkg::CMD_RIGHT;
			end
		end

		oal_cell u_cell (
			.clk        (clk),
			.ctl        (ctl_w[i]),
			.left_data  (data_w[(i == 0) ? i : i - 1]),
			.right_data (data_w[(i == CAPACITY - 1) ? i : i + 1]),
			.data       (data_w[i]),
			.match      (match_w[i])
		);
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			find_s1   <= is_find;
			status_s1 <= op_status;
			count_s1  <= ins_ok ? entry_cnt_q + CW'(1) :
				(del_ok ? entry_cnt_q - CW'(1) : entry_cnt_q);
		end
	end

	// lowest matching cell
	assign first_hit = match_w & (~match_w + CAPACITY'(1));
	assign any_hit   = |match_w;

	always_comb begin
		hit_index = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (first_hit[k]) begin
				hit_index = hit_index | oal_pkg::POS_W'(k);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_count_q <= count_s1;
			if (find_s1) begin
				out_status_q <= any_hit ? oal_pkg::ST_OK : oal_pkg::ST_NOTFOUND;
				out_index_q  <= any_hit ? hit_index : '0;
			end else begin
				out_status_q <= status_s1;
				out_index_q  <= '0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_index_q;
	assign rsp.count       = oal_pkg::POS_W'(out_count_q);

	// checks
	`include "assert_macros.svh"

	`OAL_ASSERT_ALWAYS(a_cnt_bound, entry_cnt_q <= CW'(CAPACITY))
	`OAL_ASSERT(a_find_keeps_cnt, accept && is_find |=> entry_cnt_q == $past(entry_cnt_q))
	`OAL_ASSERT(a_cnt_step, entry_cnt_q == $past(entry_cnt_q) || entry_cnt_q == $past(entry_cnt_q) + CW'(1) || entry_cnt_q == $past(entry_cnt_q) - CW'(1))
	`OAL_ASSERT(a_first_onehot, $onehot0(first_hit))
	`OAL_ASSERT(a_out_cnt_match, adv_s1 |=> out_count_q == $past(count_s1))

endmodule

### test/ordered_array_list_top_tb.sv
// testbench for the ordered array list: directed table, then random find/insert/delete traffic
module ordered_array_list_top_tb;

	localparam int unsigned LIST_CAPACITY = 8;
	localparam int unsigned ITEMS_PER_PHASE = 633;
	localparam int unsigned LONG_STALL_CYCLES = 64;
	localparam int unsigned DRAIN_CYCLES = 8;

	// request and status codes used by the table and the predictor
	localparam logic [1:0] M_FIND     = oal_pkg::MODE_FIND;
	localparam logic [1:0] M_INSERT   = oal_pkg::MODE_INSERT;
	localparam logic [1:0] M_DELETE   = oal_pkg::MODE_DELETE;
	localparam logic [1:0] S_OK       = oal_pkg::ST_OK;
	localparam logic [1:0] S_FULL     = oal_pkg::ST_FULL;
	localparam logic [1:0] S_BADPOS   = oal_pkg::ST_BADPOS;
	localparam logic [1:0] S_NOTFOUND = oal_pkg::ST_NOTFOUND;

	// request code with no operation behind it
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  found_index;
		logic [7:0]  count;
	} list_result_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] value;
		logic [7:0]  position;
	} list_request_t;

	typedef struct packed {
		list_request_t rq;
		logic          typed;
		list_result_t  result;
	} directed_row_t;

	localparam list_result_t FROM_LIST = '{S_OK, 8'd0, 8'd0};

	// values that hit the extremes or repeat often
	localparam logic [31:0] VALUE_POOL [8] = '{
		32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
		32'h0000_0001, 32'h0000_0002, 32'hffff_fffe, 32'h0000_0003
	};

	// directed walk: empty list corners, fill to full, find duplicates, delete ends
	localparam directed_row_t DIRECTED_ROWS [25] = '{
		'{'{M_FIND,      32'h0000_0000, 8'd0},   1'b1, '{S_NOTFOUND, 8'd0, 8'd0}},
		'{'{M_DELETE,    32'h0000_0000, 8'd1},   1'b1, '{S_BADPOS,   8'd0, 8'd0}},
		'{'{M_INSERT,    32'h0000_0009, 8'd0},   1'b1, '{S_BADPOS,   8'd0, 8'd0}},
		'{'{M_INSERT,    32'h0000_0009, 8'd2},   1'b1, '{S_BADPOS,   8'd0, 8'd0}},
		'{'{MODE_UNUSED, 32'hffff_ffff, 8'd255}, 1'b1, '{S_BADPOS,   8'd0, 8'd0}},
		'{'{M_INSERT,    32'h8000_0000, 8'd1},   1'b1, '{S_OK,       8'd0, 8'd1}},
		'{'{M_INSERT,    32'h7fff_ffff, 8'd2},   1'b1, '{S_OK,       8'd0, 8'd2}},
		'{'{M_INSERT,    32'h0000_0000, 8'd1},   1'b1, '{S_OK,       8'd0, 8'd3}},
		'{'{M_INSERT,    32'hffff_ffff, 8'd2},   1'b1, '{S_OK,       8'd0, 8'd4}},
		'{'{M_INSERT,    32'h5555_5555, 8'd255}, 1'b1, '{S_BADPOS,   8'd0, 8'd4}},
		'{'{M_INSERT,    32'haaaa_aaaa, 8'd5},   1'b1, '{S_OK,       8'd0, 8'd5}},
		'{'{M_INSERT,    32'hffff_ffff, 8'd3},   1'b1, '{S_OK,       8'd0, 8'd6}},
		'{'{M_INSERT,    32'h0000_0001, 8'd7},   1'b1, '{S_OK,       8'd0, 8'd7}},
		'{'{M_INSERT,    32'h0000_0002, 8'd1},   1'b1, '{S_OK,       8'd0, 8'd8}},
		'{'{M_INSERT,    32'h0000_0003, 8'd1},   1'b1, '{S_FULL,     8'd0, 8'd8}},
		'{'{M_INSERT,    32'h0000_0003, 8'd0},   1'b1, '{S_FULL,     8'd0, 8'd8}},
		'{'{M_FIND,      32'hffff_ffff, 8'd0},   1'b0, FROM_LIST},
		'{'{M_FIND,      32'h8000_0000, 8'd0},   1'b0, FROM_LIST},
		'{'{M_FIND,      32'h7fff_ffff, 8'd0},   1'b0, FROM_LIST},
		'{'{M_FIND,      32'h0000_3039, 8'd0},   1'b1, '{S_NOTFOUND, 8'd0, 8'd8}},
		'{'{M_DELETE,    32'h0000_0000, 8'd9},   1'b1, '{S_BADPOS,   8'd0, 8'd8}},
		'{'{M_DELETE,    32'h0000_0000, 8'd0},   1'b1, '{S_BADPOS,   8'd0, 8'd8}},
		'{'{M_DELETE,    32'h0000_0000, 8'd8},   1'b1, '{S_OK,       8'd0, 8'd7}},
		'{'{M_DELETE,    32'h0000_0000, 8'd1},   1'b1, '{S_OK,       8'd0, 8'd6}},
		'{'{M_FIND,      32'h0000_0002, 8'd0},   1'b0, FROM_LIST}
	};

	logic clk;
	logic arst_n;

	oal_req_if req_ch ();
	oal_rsp_if rsp_ch ();

	ordered_array_list_top #(
		.CAPACITY(LIST_CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow copy of the list
	logic [31:0]  list_cells [LIST_CAPACITY];
	int           list_len;
	list_result_t pending_results [$];

	int error_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit long_stall_req;
	int stall_left;

	// apply one request to the shadow list and return its result
	function automatic list_result_t apply_list_op(list_request_t rq);
		list_result_t r;
		int           p;
		int           k;
		r = '{S_BADPOS, 8'd0, 8'd0};
		p = int'(rq.position);
		case (rq.mode)
			M_FIND: begin
				r.status = S_NOTFOUND;
				// walk down so the lowest match wins
				for (k = list_len - 1; k >= 0; k--) begin
					if (list_cells[k] == rq.value) begin
						r.status = S_OK;
						r.found_index = 8'(k);
					end
				end
			end
			M_INSERT: begin
				if (list_len >= LIST_CAPACITY) begin
					r.status = S_FULL;
				end else if (p >= 1 && p <= list_len + 1) begin
					for (k = list_len; k >= p; k--)
						list_cells[k] = list_cells[k - 1];
					list_cells[p - 1] = rq.value;
					list_len++;
					r.status = S_OK;
				end
			end
			M_DELETE: begin
				if (p >= 1 && p <= list_len) begin
					for (k = p - 1; k + 1 < list_len; k++)
						list_cells[k] = list_cells[k + 1];
					list_len--;
					r.status = S_OK;
				end
			end
			default: begin
				r.status = S_BADPOS;
			end
		endcase
		r.count = 8'(list_len);
		return r;
	endfunction

	// value mix: full random, corner pool, or one already in the list
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = VALUE_POOL[$urandom_range(0, 7)];
			default: begin
				if (list_len > 0)
					v = list_cells[$urandom_range(0, list_len - 1)];
				else
					v = VALUE_POOL[$urandom_range(0, 7)];
			end
		endcase
		return v;
	endfunction

	// mostly well-formed requests, biased to fill or drain, plus some noise
	function automatic list_request_t random_request(bit filling);
		list_request_t rq;
		int            roll;
		roll = $urandom_range(0, 99);
		rq.value = pick_value();
		rq.position = 8'd0;
		if (roll < 6) begin
			rq.mode = 2'($urandom_range(0, 3));
			rq.value = $urandom;
			rq.position = 8'($urandom_range(0, 255));
		end else if (roll < 30) begin
			rq.mode = M_FIND;
			rq.position = 8'($urandom_range(0, 255));
		end else if (roll < (filling ? 80 : 50)) begin
			rq.mode = M_INSERT;
			rq.position = 8'($urandom_range(1, list_len + 1));
		end else begin
			rq.mode = M_DELETE;
			rq.position = (list_len == 0) ? 8'd1 : 8'($urandom_range(1, list_len));
		end
		return rq;
	endfunction

	// offer one request transaction, predict on acceptance
	task automatic drive_request(input list_request_t rq, input logic typed,
			input list_result_t typed_result);
		list_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= rq.mode;
		req_ch.value <= rq.value;
		req_ch.position <= rq.position;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = apply_list_op(rq);
		pending_results.push_back(typed ? typed_result : predicted);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// response side: random backpressure plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left = LONG_STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// compare each response transaction with the oldest prediction
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected response: expected none, %s %0d %0d %0d",
					$time, "actual status/index/count", rsp_ch.status,
					rsp_ch.found_index, rsp_ch.count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t status mismatch: expected %0d actual %0d",
						$time, want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.found_index !== want.found_index) begin
					$display("%0t found_index mismatch: expected %0d actual %0d",
						$time, want.found_index, rsp_ch.found_index);
					error_count++;
				end
				if (rsp_ch.count !== want.count) begin
					$display("%0t count mismatch: expected %0d actual %0d",
						$time, want.count, rsp_ch.count);
					error_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL ordered_array_list_top");
		$finish;
	end

	// stimulus
	initial begin
		bit filling;
		error_count = 0;
		long_stall_req = 1'b0;
		list_len = 0;
		filling = 1'b0;
		send_idle_pct = 24;
		recv_idle_pct = 57;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = M_FIND;
		req_ch.value = '0;
		req_ch.position = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			drive_request(DIRECTED_ROWS[i].rq, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);

		for (int phase = 0; phase < 3; phase++) begin
			// pause until the list has answered everything, then change pacing
			if (phase > 0) begin
				req_ch.valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 57 : 0;
			recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 24 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 2 && n == 100)
					long_stall_req = 1'b1;
				if (n % 48 == 0)
					filling = ~filling;
				drive_request(random_request(filling), 1'b0, FROM_LIST);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("PASS ordered_array_list_top");
		else
			$display("FAIL ordered_array_list_top");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/oal_pkg.sv
hdl/oal_ifs.sv
hdl/oal_cell.sv
hdl/ordered_array_list_top.sv
test/ordered_array_list_top_tb.sv
